FILE: design/assert_macros.svh
// Assertion macros shared by the design files.
// Each macro expands to a clocked concurrent assertion, or to nothing in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Implication that must hold at every rising edge outside reset.
`define ASSERT_CLKD(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Combinational condition sampled at every rising edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`else
`define ASSERT_CLKD(label, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg)
`endif
`endif

FILE: design/sfdm_pkg.sv
// Package for the signed floor divide and modulo unit.
// Holds the data width, stage record types and numeric constants; no dependencies.
`timescale 1ns / 1ps
package sfdm_pkg;

    localparam int unsigned DATA_W = 64;

    localparam logic [DATA_W-1:0] MIN_VALUE     = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic [DATA_W-1:0] MINUS_ONE     = {DATA_W{1'b1}};
    localparam logic [DATA_W-1:0] ZERO_VALUE    = {DATA_W{1'b0}};

    // Sign and exception flags that ride along with each operand pair.
    typedef struct packed {
        logic nneg;
        logic dneg;
        logic dz;
        logic ov;
    } sfdm_ctrl_t;

    // Working data carried from cell to cell.
    typedef struct packed {
        logic [DATA_W-1:0] rem;
        logic [DATA_W-1:0] quo;
        logic [DATA_W-1:0] den_mag;
    } sfdm_data_t;

endpackage

FILE: design/sfdm_if.sv
// Valid/ready channel interfaces for the operand and result streams.
// Depends on sfdm_pkg for the data width.
`timescale 1ns / 1ps
interface sfdm_in_if
    import sfdm_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] dividend;
    logic signed [DATA_W-1:0] divisor;

    modport source (output valid, output dividend, output divisor, input ready);
    modport sink (input valid, input dividend, input divisor, output ready);
endinterface

interface sfdm_out_if
    import sfdm_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] quotient;
    logic signed [DATA_W-1:0] remainder;
    logic                     divide_by_zero;
    logic                     overflow;

    modport source (output valid, output quotient, output remainder,
                    output divide_by_zero, output overflow, input ready);
    modport sink (input valid, input quotient, input remainder,
                  input divide_by_zero, input overflow, output ready);
endinterface

FILE: design/sfdm_prep.sv
// Entry stage: takes operand magnitudes and detects the exception cases.
// Depends on sfdm_pkg.
`timescale 1ns / 1ps
module sfdm_prep
    import sfdm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic              in_valid,
    input  logic [DATA_W-1:0] dividend,
    input  logic [DATA_W-1:0] divisor,
    output logic              valid_reg,
    output sfdm_ctrl_t        ctrl_reg,
    output sfdm_data_t        data_reg
);

    sfdm_ctrl_t ctrl_next;
    sfdm_data_t data_next;

    // Signs, magnitudes and special cases of the incoming pair.
    always_comb
    begin
        ctrl_next.nneg = dividend[DATA_W-1];
        ctrl_next.dneg = divisor[DATA_W-1];
        ctrl_next.dz   = (divisor == ZERO_VALUE);
        ctrl_next.ov   = (dividend == MIN_VALUE) && (divisor == MINUS_ONE);
        data_next.rem  = ZERO_VALUE;
        data_next.quo  = dividend[DATA_W-1] ? (ZERO_VALUE - dividend) : dividend;
        data_next.den_mag = divisor[DATA_W-1] ? (ZERO_VALUE - divisor) : divisor;
    end

    // Stage valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    // Stage payload.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ctrl_reg <= ctrl_next;
            data_reg <= data_next;
        end
    end

endmodule

FILE: design/sfdm_cell.sv
// One restoring-division cell: produces one quotient bit per pass.
// Depends on sfdm_pkg.
`timescale 1ns / 1ps
module sfdm_cell
    import sfdm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       advance,
    input  logic       valid_in,
    input  sfdm_ctrl_t ctrl_in,
    input  sfdm_data_t data_in,
    output logic       valid_reg,
    output sfdm_ctrl_t ctrl_reg,
    output sfdm_data_t data_reg
);

    logic [DATA_W-1:0] shifted;
    logic [DATA_W:0]   trial;
    logic              fits;
    sfdm_data_t        data_next;

    // Shift the next dividend bit into the partial remainder and try a subtract.
    always_comb
    begin
        shifted = {data_in.rem[DATA_W-2:0], data_in.quo[DATA_W-1]};
        trial   = {1'b0, shifted} - {1'b0, data_in.den_mag};
        fits    = !trial[DATA_W];
        data_next.rem     = fits ? trial[DATA_W-1:0] : shifted;
        data_next.quo     = {data_in.quo[DATA_W-2:0], fits};
        data_next.den_mag = data_in.den_mag;
    end

    // Cell valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= valid_in;
        end
    end

    // Cell payload.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ctrl_reg <= ctrl_in;
            data_reg <= data_next;
        end
    end

endmodule

FILE: design/sfdm_fix.sv
// Exit stage: applies floor rounding and signs, and holds the result register.
// Depends on sfdm_pkg.
`timescale 1ns / 1ps
module sfdm_fix
    import sfdm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic              valid_in,
    input  sfdm_ctrl_t        ctrl_in,
    input  sfdm_data_t        data_in,
    output logic              valid_reg,
    output logic [DATA_W-1:0] quotient_reg,
    output logic [DATA_W-1:0] remainder_reg,
    output logic              dz_reg,
    output logic              ov_reg
);

    logic              mixed;
    logic              inexact;
    logic [DATA_W-1:0] sub_a;
    logic [DATA_W-1:0] sub_b;
    logic [DATA_W-1:0] quotient_next;
    logic [DATA_W-1:0] remainder_next;

    // Floor correction; the remainder needs a single subtract with chosen operands.
    always_comb
    begin
        mixed   = ctrl_in.nneg ^ ctrl_in.dneg;
        inexact = (data_in.rem != ZERO_VALUE);
        sub_a   = ZERO_VALUE;
        sub_b   = ZERO_VALUE;
        if (!mixed)
        begin
            quotient_next = data_in.quo;
            if (ctrl_in.nneg)
            begin
                sub_b = data_in.rem;
            end
            else
            begin
                sub_a = data_in.rem;
            end
        end
        else if (inexact)
        begin
            // Negated quotient minus one is the bitwise complement.
            quotient_next = ~data_in.quo;
            if (ctrl_in.nneg)
            begin
                sub_a = data_in.den_mag;
                sub_b = data_in.rem;
            end
            else
            begin
                sub_a = data_in.rem;
                sub_b = data_in.den_mag;
            end
        end
        else
        begin
            quotient_next = ZERO_VALUE - data_in.quo;
        end
        remainder_next = sub_a - sub_b;
        if (ctrl_in.dz)
        begin
            quotient_next  = ZERO_VALUE;
            remainder_next = ZERO_VALUE;
        end
    end

    // Result valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= valid_in;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            quotient_reg  <= quotient_next;
            remainder_reg <= remainder_next;
            dz_reg        <= ctrl_in.dz;
            ov_reg        <= ctrl_in.ov;
        end
    end

endmodule

FILE: design/signed_floor_divide_modulo_64_unit.sv
// Signed 64-bit floor divide and modulo: entry stage, 64 division cells, exit stage.
// Each cell resolves one quotient bit; a pair moves through every stage register in order.
// Throughput is one operand pair per cycle unless the output stalls.
// A stalled result register holds the whole chain, so input ready follows output space.
// Reset (rst_n low, asynchronous) clears every valid flag; no result is pending afterwards.
// Depends on sfdm_pkg, sfdm_if, sfdm_prep, sfdm_cell, sfdm_fix and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module signed_floor_divide_modulo_64_unit
    import sfdm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    sfdm_in_if.sink           in_ch,
    sfdm_out_if.source        out_ch
);

    logic       advance;
    logic       valid_chain [DATA_W+1];
    sfdm_ctrl_t ctrl_chain  [DATA_W+1];
    sfdm_data_t data_chain  [DATA_W+1];
    logic       out_valid_reg;
    logic [DATA_W-1:0] quotient_reg;
    logic [DATA_W-1:0] remainder_reg;
    logic       dz_reg;
    logic       ov_reg;

    // The chain moves whenever the result register is empty or being transferred.
    assign advance     = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = advance;

    sfdm_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (in_ch.valid),
        .dividend  (in_ch.dividend),
        .divisor   (in_ch.divisor),
        .valid_reg (valid_chain[0]),
        .ctrl_reg  (ctrl_chain[0]),
        .data_reg  (data_chain[0])
    );

    // Row of division cells, one quotient bit each, most significant first.
    for (genvar i = 0; i < DATA_W; i++)
    begin : g_cell
        sfdm_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .valid_in  (valid_chain[i]),
            .ctrl_in   (ctrl_chain[i]),
            .data_in   (data_chain[i]),
            .valid_reg (valid_chain[i+1]),
            .ctrl_reg  (ctrl_chain[i+1]),
            .data_reg  (data_chain[i+1])
        );
    end

    sfdm_fix u_fix (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .valid_in      (valid_chain[DATA_W]),
        .ctrl_in       (ctrl_chain[DATA_W]),
        .data_in       (data_chain[DATA_W]),
        .valid_reg     (out_valid_reg),
        .quotient_reg  (quotient_reg),
        .remainder_reg (remainder_reg),
        .dz_reg        (dz_reg),
        .ov_reg        (ov_reg)
    );

    // Result channel.
    assign out_ch.valid          = out_valid_reg;
    assign out_ch.quotient       = quotient_reg;
    assign out_ch.remainder      = remainder_reg;
    assign out_ch.divide_by_zero = dz_reg;
    assign out_ch.overflow       = ov_reg;

    // A zero divisor yields zero quotient and remainder.
    `ASSERT_CLKD(a_dz_zero, clk, rst_n, (out_valid_reg && dz_reg) |-> (quotient_reg == ZERO_VALUE && remainder_reg == ZERO_VALUE), "divide by zero result not cleared")
    // Overflow gives the wrapped minimum quotient and no remainder.
    `ASSERT_CLKD(a_ov_wrap, clk, rst_n, (out_valid_reg && ov_reg) |-> (quotient_reg == MIN_VALUE && remainder_reg == ZERO_VALUE), "overflow result malformed")
    // The two exception flags never appear together.
    `ASSERT_ALWAYS(a_flags_excl, clk, rst_n, !(out_valid_reg && dz_reg && ov_reg), "both exception flags set")
    // A stalled result holds while the chain stays frozen behind it.
    `ASSERT_CLKD(a_hold, clk, rst_n, (out_valid_reg && !out_ch.ready) |=> (out_valid_reg && $stable(quotient_reg) && $stable(valid_chain[DATA_W])), "stalled result changed")

endmodule
